### rtl/core/assert_macros.svh
// Assertion macros used by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define GPW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Check a property on every rising edge, reset included.
`define GPW_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define GPW_ASSERT(lbl, clk, rst, prop)
`define GPW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/gpw_pkg.sv
package gpw_pkg;

   localparam int SENSOR_W = 10;
   localparam int COORD_W  = 4;
   localparam int WALL_W   = 4;

   // operation codes
   localparam logic [2:0] OP_CLEAR   = 3'd0;
   localparam logic [2:0] OP_RIGHT   = 3'd1;
   localparam logic [2:0] OP_LEFT    = 3'd2;
   localparam logic [2:0] OP_AROUND  = 3'd3;
   localparam logic [2:0] OP_FORWARD = 3'd4;
   localparam logic [2:0] OP_MAP     = 3'd5;
   localparam logic [2:0] OP_READ    = 3'd6;

   // headings
   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   // heading offsets for turns and side sensors
   localparam logic [1:0] TURN_RIGHT  = 2'd1;
   localparam logic [1:0] TURN_AROUND = 2'd2;
   localparam logic [1:0] TURN_LEFT   = 2'd3;

   // register indexes
   localparam logic CSR_FRONT_THRESHOLD = 1'b0;
   localparam logic CSR_SIDE_THRESHOLD  = 1'b1;

   localparam logic [SENSOR_W-1:0] THRESHOLD_RESET = 10'd500;

   // map update steps: current cell, then neighbors north, east, south, west
   localparam logic [2:0] STEP_CUR = 3'd0;
   localparam logic [2:0] STEP_N   = 3'd1;
   localparam logic [2:0] STEP_E   = 3'd2;
   localparam logic [2:0] STEP_S   = 3'd3;
   localparam logic [2:0] STEP_W   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MAP_RD,
      ST_MAP_WR,
      ST_READ_WAIT
   } state_type;

   typedef struct packed {
      logic [2:0]          operation;
      logic [SENSOR_W-1:0] front_reading;
      logic [SENSOR_W-1:0] left_reading;
      logic [SENSOR_W-1:0] right_reading;
      logic [COORD_W-1:0]  query_x;
      logic [COORD_W-1:0]  query_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] position_x;
      logic [COORD_W-1:0] position_y;
      logic [1:0]         heading;
      logic [WALL_W-1:0]  cell_walls;
   } rsp_type;

   typedef struct packed {
      logic [SENSOR_W-1:0] front_threshold;
      logic [SENSOR_W-1:0] side_threshold;
   } cfg_type;

   function automatic logic [WALL_W-1:0] wall_bit(input logic [1:0] dir);
      return WALL_W'(1) << dir;
   endfunction

endpackage

### rtl/core/gpw_wall_ram.sv
module gpw_wall_ram #(
   parameter int DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   input  logic [gpw_pkg::WALL_W-1:0]   wdata,
   output logic [gpw_pkg::WALL_W-1:0]   rdata
);

   logic [gpw_pkg::WALL_W-1:0] mem [DEPTH];
   logic [gpw_pkg::WALL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/gpw_ctrl.sv
`include "assert_macros.svh"

module gpw_ctrl #(
   parameter int GRID_SIZE = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  gpw_pkg::req_type                   req,
   input  gpw_pkg::cfg_type                   cfg,
   output logic                               rsp_valid,
   output gpw_pkg::rsp_type                   rsp,
   output logic                               ram_we,
   output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] ram_addr,
   output logic [gpw_pkg::WALL_W-1:0]         ram_wdata,
   input  logic [gpw_pkg::WALL_W-1:0]         ram_rdata
);

   localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = $clog2(GRID_SIZE);
   localparam logic [POS_W-1:0]  TOP       = POS_W'(GRID_SIZE - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] x,
                                                   input logic [POS_W-1:0] y);
      return ADDR_W'(int'(x) * GRID_SIZE + int'(y));
   endfunction

   gpw_pkg::state_type          state_ff, state_in;
   logic [POS_W-1:0]            x_ff, x_in, y_ff, y_in;
   logic [1:0]                  hd_ff, hd_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;
   logic                        clr_op_ff, clr_op_in;
   logic [2:0]                  step_ff, step_in;
   logic [gpw_pkg::WALL_W-1:0]  walls_ff, walls_in;
   logic [gpw_pkg::WALL_W-1:0]  cur_ff, cur_in;
   logic [ADDR_W-1:0]           addr_ff, addr_in;
   logic [gpw_pkg::WALL_W-1:0]  bits_ff, bits_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   gpw_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        accept;
   logic                        step_en;
   logic [gpw_pkg::WALL_W-1:0]  step_bits;
   logic [ADDR_W-1:0]           step_addr;
   logic [gpw_pkg::WALL_W-1:0]  sensed;
   logic                        query_ok;

   assign busy   = (state_ff != gpw_pkg::ST_IDLE);
   assign accept = start && !busy;

   // absolute walls seen by the sensors at the current heading
   always_comb begin
      sensed = '0;
      if (req.front_reading > cfg.front_threshold) begin
         sensed = sensed | gpw_pkg::wall_bit(hd_ff);
      end
      if (req.right_reading > cfg.side_threshold) begin
         sensed = sensed | gpw_pkg::wall_bit(hd_ff + gpw_pkg::TURN_RIGHT);
      end
      if (req.left_reading > cfg.side_threshold) begin
         sensed = sensed | gpw_pkg::wall_bit(hd_ff + gpw_pkg::TURN_LEFT);
      end
   end

   assign query_ok = (int'(req.query_x) < GRID_SIZE) && (int'(req.query_y) < GRID_SIZE);

   // target of the current map step
   always_comb begin
      step_en   = 1'b0;
      step_bits = '0;
      step_addr = cell_addr(x_ff, y_ff);
      unique case (step_ff)
         gpw_pkg::STEP_CUR: begin
            step_en   = 1'b1;
            step_bits = walls_ff;
         end
         gpw_pkg::STEP_N: begin
            step_en   = walls_ff[gpw_pkg::DIR_N] && (y_ff < TOP);
            step_bits = gpw_pkg::wall_bit(gpw_pkg::DIR_S);
            step_addr = cell_addr(x_ff, y_ff + POS_W'(1));
         end
         gpw_pkg::STEP_E: begin
            step_en   = walls_ff[gpw_pkg::DIR_E] && (x_ff < TOP);
            step_bits = gpw_pkg::wall_bit(gpw_pkg::DIR_W);
            step_addr = cell_addr(x_ff + POS_W'(1), y_ff);
         end
         gpw_pkg::STEP_S: begin
            step_en   = walls_ff[gpw_pkg::DIR_S] && (y_ff != '0);
            step_bits = gpw_pkg::wall_bit(gpw_pkg::DIR_N);
            step_addr = cell_addr(x_ff, y_ff - POS_W'(1));
         end
         gpw_pkg::STEP_W: begin
            step_en   = walls_ff[gpw_pkg::DIR_W] && (x_ff != '0);
            step_bits = gpw_pkg::wall_bit(gpw_pkg::DIR_E);
            step_addr = cell_addr(x_ff - POS_W'(1), y_ff);
         end
         default: begin
            step_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      logic                       emit;
      logic [gpw_pkg::WALL_W-1:0] emit_walls;
      state_in   = state_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      hd_in      = hd_ff;
      clr_in     = clr_ff;
      clr_op_in  = clr_op_ff;
      step_in    = step_ff;
      walls_in   = walls_ff;
      cur_in     = cur_ff;
      addr_in    = addr_ff;
      bits_in    = bits_ff;
      emit       = 1'b0;
      emit_walls = '0;
      ram_we     = 1'b0;
      ram_addr   = addr_ff;
      ram_wdata  = ram_rdata | bits_ff;
      unique case (state_ff)
         gpw_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req.operation)
                  gpw_pkg::OP_CLEAR: begin
                     x_in      = '0;
                     y_in      = '0;
                     hd_in     = gpw_pkg::DIR_N;
                     clr_in    = '0;
                     clr_op_in = 1'b1;
                     state_in  = gpw_pkg::ST_CLEAR;
                  end
                  gpw_pkg::OP_RIGHT: begin
                     hd_in = hd_ff + gpw_pkg::TURN_RIGHT;
                     emit  = 1'b1;
                  end
                  gpw_pkg::OP_LEFT: begin
                     hd_in = hd_ff + gpw_pkg::TURN_LEFT;
                     emit  = 1'b1;
                  end
                  gpw_pkg::OP_AROUND: begin
                     hd_in = hd_ff + gpw_pkg::TURN_AROUND;
                     emit  = 1'b1;
                  end
                  gpw_pkg::OP_FORWARD: begin
                     unique case (hd_ff)
                        gpw_pkg::DIR_N: if (y_ff < TOP)  y_in = y_ff + POS_W'(1);
                        gpw_pkg::DIR_E: if (x_ff < TOP)  x_in = x_ff + POS_W'(1);
                        gpw_pkg::DIR_S: if (y_ff != '0) y_in = y_ff - POS_W'(1);
                        default:        if (x_ff != '0) x_in = x_ff - POS_W'(1);
                     endcase
                     emit = 1'b1;
                  end
                  gpw_pkg::OP_MAP: begin
                     walls_in = sensed;
                     step_in  = gpw_pkg::STEP_CUR;
                     state_in = gpw_pkg::ST_MAP_RD;
                  end
                  gpw_pkg::OP_READ: begin
                     if (query_ok) begin
                        ram_addr = cell_addr(POS_W'(req.query_x), POS_W'(req.query_y));
                        state_in = gpw_pkg::ST_READ_WAIT;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         gpw_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in  = gpw_pkg::ST_IDLE;
               emit      = clr_op_ff;
               clr_op_in = 1'b0;
            end
         end
         gpw_pkg::ST_MAP_RD: begin
            if (step_en) begin
               ram_addr = step_addr;
               addr_in  = step_addr;
               bits_in  = step_bits;
               state_in = gpw_pkg::ST_MAP_WR;
            end else if (step_ff == gpw_pkg::STEP_W) begin
               emit       = 1'b1;
               emit_walls = cur_ff;
               state_in   = gpw_pkg::ST_IDLE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         gpw_pkg::ST_MAP_WR: begin
            ram_we = 1'b1;
            if (step_ff == gpw_pkg::STEP_CUR) begin
               cur_in = ram_wdata;
            end
            if (step_ff == gpw_pkg::STEP_W) begin
               emit       = 1'b1;
               emit_walls = cur_ff;
               state_in   = gpw_pkg::ST_IDLE;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = gpw_pkg::ST_MAP_RD;
            end
         end
         gpw_pkg::ST_READ_WAIT: begin
            emit       = 1'b1;
            emit_walls = ram_rdata;
            state_in   = gpw_pkg::ST_IDLE;
         end
         default: begin
            state_in = gpw_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in      = emit;
      rsp_in.position_x = gpw_pkg::COORD_W'(x_in);
      rsp_in.position_y = gpw_pkg::COORD_W'(y_in);
      rsp_in.heading    = hd_in;
      rsp_in.cell_walls = emit_walls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gpw_pkg::ST_CLEAR;
         x_ff         <= '0;
         y_ff         <= '0;
         hd_ff        <= gpw_pkg::DIR_N;
         clr_ff       <= '0;
         clr_op_ff    <= 1'b0;
         step_ff      <= gpw_pkg::STEP_CUR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         hd_ff        <= hd_in;
         clr_ff       <= clr_in;
         clr_op_ff    <= clr_op_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walls_ff <= walls_in;
      cur_ff   <= cur_in;
      addr_ff  <= addr_in;
      bits_ff  <= bits_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `GPW_ASSERT(a_write_states, clock, reset, ram_we |-> (state_ff == gpw_pkg::ST_CLEAR || state_ff == gpw_pkg::ST_MAP_WR))
   `GPW_ASSERT(a_accept_progress, clock, reset, accept |=> (rsp_valid_ff || busy))
   `GPW_ASSERT(a_step_range, clock, reset, (state_ff == gpw_pkg::ST_MAP_WR) |-> (step_ff <= gpw_pkg::STEP_W))
   `GPW_ASSERT_ALWAYS(a_reset_sweep, clock, $past(reset) |-> (state_ff == gpw_pkg::ST_CLEAR))

endmodule

### rtl/core/grid_pose_and_wall_map_core.sv
// Turn, forward and unused codes answer straight from idle; read passes through a wait
// state for the wall memory; map cell does one read-modify-write of the wall memory per
// marked cell (the current cell and up to three neighbors).
// Clear walks the wall memory one entry per cycle.
// Throughput: one request at a time; the next is taken once busy drops.
// Reset (synchronous) runs the same clearing pass of the wall memory.
// The result strobe lasts one cycle; the receiver cannot stall.
module grid_pose_and_wall_map_core #(
   parameter int GRID_SIZE = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  gpw_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_valid,
   output gpw_pkg::rsp_type                  rsp_data,
   // register write port
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [gpw_pkg::SENSOR_W-1:0]      csr_wdata
);

   localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);

   // threshold registers; the user is to write them only while idle, the block does not enforce it
   gpw_pkg::cfg_type cfg_ff, cfg_in;

   logic                        ram_we;
   logic [ADDR_W-1:0]           ram_addr;
   logic [gpw_pkg::WALL_W-1:0]  ram_wdata;
   logic [gpw_pkg::WALL_W-1:0]  ram_rdata;

   // decode the register index; hold the other register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            gpw_pkg::CSR_FRONT_THRESHOLD: cfg_in.front_threshold = csr_wdata;
            gpw_pkg::CSR_SIDE_THRESHOLD:  cfg_in.side_threshold  = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_threshold <= gpw_pkg::THRESHOLD_RESET;
         cfg_ff.side_threshold  <= gpw_pkg::THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: pose registers, clearing sweep and wall read-modify-write
   gpw_ctrl #(
      .GRID_SIZE (GRID_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req_data),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   // wall map: one entry per cell, indexed x * GRID_SIZE + y
   gpw_wall_ram #(
      .DEPTH (DEPTH)
   ) u_wall_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule
